// File: design/hnpt_pkg.sv
// ----------------------------------------------------------------------------
// hnpt_pkg: shared types and codes for the heartbeat node presence table
// Holds the input item and result records, the command and status codes and
// the reset value of the timeout register.
// ----------------------------------------------------------------------------
package hnpt_pkg;

  // Command codes; any code with bit 1 set is treated as a lookup
  localparam logic [1:0] CMD_HEARTBEAT = 2'd0;
  localparam logic [1:0] CMD_SWEEP     = 2'd1;

  // Result status codes
  localparam logic [2:0] ST_REFRESHED  = 3'd0;
  localparam logic [2:0] ST_REGISTERED = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_HIT        = 3'd3;
  localparam logic [2:0] ST_MISS       = 3'd4;
  localparam logic [2:0] ST_SWEPT      = 3'd5;

  // Timeout after reset, in milliseconds
  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  // One input transaction
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] node_id;
    logic [31:0] now_ms;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_index;
    logic       evicted_any;
    logic [3:0] module_count;
  } result_t;

endpackage

// File: design/hnpt_in_reg.sv
// ----------------------------------------------------------------------------
// hnpt_in_reg: input register stage
// Captures one input transaction and holds it until the table consumes it.
// ----------------------------------------------------------------------------
module hnpt_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hnpt_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output hnpt_pkg::item_t item_o
);
  import hnpt_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Register is free when empty or when its content is consumed this cycle
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: design/hnpt_table.sv
// ----------------------------------------------------------------------------
// hnpt_table: slot storage with combinational match, allocate and sweep
// Compares the item against all slots in parallel, picks the lowest matching
// or free slot, evaluates expiry per slot and updates the slots on fire_i.
// ----------------------------------------------------------------------------
module hnpt_table #(
  parameter int SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  hnpt_pkg::item_t   item_i,
  input  logic [31:0]       timeout_ms_i,
  output hnpt_pkg::result_t res_o
);
  import hnpt_pkg::*;

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [31:0]      node_q [SLOTS];
  logic [31:0]      seen_q [SLOTS];

  logic [SLOTS-1:0] node_we, seen_we, expired;
  logic             hit_any, free_any;
  logic [SlotW-1:0] hit_idx, free_idx;
  logic [CntW-1:0]  count;
  logic [31:0]      elapsed;

  // Parallel match, free search and expiry check; lowest slot wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    expired  = '0;
    elapsed  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && (node_q[i] == item_i.node_id)) begin
        hit_any = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SlotW'(i);
      end
      elapsed    = item_i.now_ms - seen_q[i];
      expired[i] = valid_q[i] && (elapsed > timeout_ms_i);
    end
  end

  // Command decode, next slot state and count of valid slots after this item
  always_comb begin
    valid_d            = valid_q;
    node_we            = '0;
    seen_we            = '0;
    res_o.status       = ST_MISS;
    res_o.slot_index   = '0;
    res_o.evicted_any  = 1'b0;
    unique case (item_i.command)
      CMD_HEARTBEAT: begin
        if (hit_any) begin
          seen_we[hit_idx] = 1'b1;
          res_o.status     = ST_REFRESHED;
          res_o.slot_index = 3'(hit_idx);
        end else if (free_any) begin
          valid_d[free_idx] = 1'b1;
          node_we[free_idx] = 1'b1;
          seen_we[free_idx] = 1'b1;
          res_o.status      = ST_REGISTERED;
          res_o.slot_index  = 3'(free_idx);
        end else begin
          res_o.status = ST_FULL;
        end
      end
      CMD_SWEEP: begin
        valid_d           = valid_q & ~expired;
        res_o.evicted_any = |expired;
        res_o.status      = ST_SWEPT;
      end
      default: begin
        // lookup
        if (hit_any) begin
          res_o.status     = ST_HIT;
          res_o.slot_index = 3'(hit_idx);
        end
      end
    endcase
    count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      count = count + CntW'(valid_d[i]);
    end
    res_o.module_count = 4'(count);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fire_i) begin
      valid_q <= valid_d;
    end
  end

  // Slot payload, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (fire_i && node_we[i]) begin
        node_q[i] <= item_i.node_id;
      end
      if (fire_i && seen_we[i]) begin
        seen_q[i] <= item_i.now_ms;
      end
    end
  end

endmodule

// File: design/hnpt_out_reg.sv
// ----------------------------------------------------------------------------
// hnpt_out_reg: result register stage
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module hnpt_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hnpt_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hnpt_pkg::result_t res_o
);
  import hnpt_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Accept a new result when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: design/heartbeat_node_presence_table.sv
// ----------------------------------------------------------------------------
// heartbeat_node_presence_table: table of remote node slots
// Heartbeat, sweep and lookup commands over a small table of node slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries command_i, node_id_i and
//   now_ms_i. Command 0 registers or refreshes a node, 1 evicts slots older
//   than the timeout, 2 (and 3) look a node up.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per input transaction, in order.
//   Config channel (cfg_valid_i / cfg_ready_o) writes timeout_ms; it is
//   always ready and should only be written while the block is idle.
//   Path: an accepted transaction is held in the input register, and its
//   result is captured in the output register once that register has room.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the parallel match of all slots is combinational and all slot registers update together.
//   Reset clears all valid bits and loads a 5000 ms timeout.
//   When the receiver stalls, the result register holds; the input register
//   fills next and then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module heartbeat_node_presence_table #(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] node_id_i,
  input  logic [31:0] now_ms_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  slot_index_o,
  output logic        evicted_any_o,
  output logic [3:0]  module_count_o,
  // config channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import hnpt_pkg::*;

  item_t       in_item, stage_item;
  result_t     table_res, out_res;
  logic        stage_valid, out_ready, fire;
  logic [31:0] timeout_q;

  // Timeout register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  assign in_item.command = command_i;
  assign in_item.node_id = node_id_i;
  assign in_item.now_ms  = now_ms_i;

  // Item is processed when staged and the result register has room
  assign fire = stage_valid && out_ready;

  hnpt_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (fire),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  hnpt_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .item_i       (stage_item),
    .timeout_ms_i (timeout_q),
    .res_o        (table_res)
  );

  hnpt_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .res_i       (table_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign status_o       = out_res.status;
  assign slot_index_o   = out_res.slot_index;
  assign evicted_any_o  = out_res.evicted_any;
  assign module_count_o = out_res.module_count;

endmodule

// File: tb/tb_heartbeat_node_presence_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heartbeat_node_presence_table: self-checking bench for the node table
// Drives heartbeat, sweep and lookup transactions with random sender gaps and
// receiver stalls. A local copy of the slot table predicts each result, and
// every result is checked field by field in order. Directed tests cover table
// fill and overflow, refresh, lookups (both lookup codes), the sweep threshold,
// time wrap, and zero and widest timeouts. Random phases then run under
// several timeout settings.
// ----------------------------------------------------------------------------
module tb_heartbeat_node_presence_table;
  import hnpt_pkg::*;

  localparam int SLOTS          = 8;
  localparam int POOL_SIZE      = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRINT_LIMIT    = 40;

  // Lookup codes: bit 1 of the command selects a lookup
  localparam logic [1:0] CMD_LOOKUP     = 2'd2;
  localparam logic [1:0] CMD_LOOKUP_ALT = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  // DUT connections
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i     = '0;
  logic [31:0] node_id_i     = '0;
  logic [31:0] now_ms_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  status_o;
  logic [2:0]  slot_index_o;
  logic        evicted_any_o;
  logic [3:0]  module_count_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = '0;

  // Handshake snapshots taken at the falling edge, used at the next rising edge
  logic        in_take_s  = 1'b0;
  logic        out_take_s = 1'b0;
  logic        cfg_take_s = 1'b0;
  result_t     out_snap;

  // Predicted table state
  logic        slot_used  [SLOTS];
  logic [31:0] slot_id    [SLOTS];
  logic [31:0] slot_stamp [SLOTS];
  logic [31:0] timeout_cur;

  result_t     pending_results [$];
  logic [31:0] node_pool [POOL_SIZE];
  logic [31:0] clock_ms;

  int          burst_left;
  int          error_count;
  int          items_sent;
  int          results_checked;
  int          timeout_writes;
  int          evicting_sweeps;
  int          status_tally [6];
  int          idle_cycles;
  int          stall_left;
  int          stall_phase;
  stall_style_t stall_style;

  heartbeat_node_presence_table #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .node_id_i     (node_id_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .evicted_any_o (evicted_any_o),
    .module_count_o(module_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sample handshakes mid-cycle; inputs and outputs only move at the rising edge
  always @(negedge clk_i) begin
    in_take_s  = in_valid_i && !in_stall_o;
    out_take_s = out_valid_o && !out_stall_i;
    cfg_take_s = cfg_valid_i && cfg_ready_o;
    out_snap   = '{status: status_o, slot_index: slot_index_o,
                   evicted_any: evicted_any_o, module_count: module_count_o};
  end

  // Receiver stall pattern: alternating stretches of different styles
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(8, 64);
    end
    stall_left--;
    stall_phase++;
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_phase % 5) < 2);
    endcase
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni || in_take_s || out_take_s || cfg_take_s) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TIMEOUT: no transaction for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, pending_results.size());
      $display("tb_heartbeat_node_presence_table NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (out_take_s) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d slot %0d count %0d",
                                  out_snap.status, out_snap.slot_index,
                                  out_snap.module_count));
      end else begin
        want = pending_results.pop_front();
        if (out_snap.status !== want.status)
          report_mismatch($sformatf("result %0d status want %0d got %0d",
                                    results_checked, want.status, out_snap.status));
        if (out_snap.slot_index !== want.slot_index)
          report_mismatch($sformatf("result %0d slot_index want %0d got %0d",
                                    results_checked, want.slot_index, out_snap.slot_index));
        if (out_snap.evicted_any !== want.evicted_any)
          report_mismatch($sformatf("result %0d evicted_any want %0d got %0d",
                                    results_checked, want.evicted_any, out_snap.evicted_any));
        if (out_snap.module_count !== want.module_count)
          report_mismatch($sformatf("result %0d module_count want %0d got %0d",
                                    results_checked, want.module_count,
                                    out_snap.module_count));
      end
      results_checked++;
    end
  end

  // Apply one transaction to the local table and return the expected result
  function automatic result_t table_apply(input logic [1:0] cmd, input logic [31:0] id,
                                          input logic [31:0] now);
    result_t res;
    int      found;
    int      vacant;
    int      live;
    res    = '0;
    found  = -1;
    vacant = -1;
    live   = 0;
    // lowest matching slot and lowest free slot
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_used[s] && slot_id[s] == id) found = s;
      if (!slot_used[s]) vacant = s;
    end
    case (cmd)
      CMD_HEARTBEAT: begin
        if (found >= 0) begin
          slot_stamp[found] = now;
          res.status        = ST_REFRESHED;
          res.slot_index    = 3'(found);
        end else if (vacant >= 0) begin
          slot_used[vacant]  = 1'b1;
          slot_id[vacant]    = id;
          slot_stamp[vacant] = now;
          res.status         = ST_REGISTERED;
          res.slot_index     = 3'(vacant);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_SWEEP: begin
        // elapsed time wraps modulo 2^32; evict only strictly above timeout
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_used[s] && (now - slot_stamp[s]) > timeout_cur) begin
            slot_used[s]    = 1'b0;
            res.evicted_any = 1'b1;
          end
        end
        res.status = ST_SWEPT;
      end
      default: begin
        if (found >= 0) begin
          res.status     = ST_HIT;
          res.slot_index = 3'(found);
        end else begin
          res.status = ST_MISS;
        end
      end
    endcase
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_used[s]) live++;
    end
    res.module_count = 4'(live);
    return res;
  endfunction

  // Send one transaction; the sender works in bursts with random gaps
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] id,
                           input logic [31:0] now);
    int      gap;
    result_t res;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    node_id_i  <= id;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_take_s !== 1'b1);
    res = table_apply(cmd, id, now);
    pending_results.push_back(res);
    status_tally[res.status]++;
    if (res.evicted_any) evicting_sweeps++;
    items_sent++;
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_take_s !== 1'b1);
    cfg_valid_i <= 1'b0;
    timeout_cur = value;
    timeout_writes++;
  endtask

  // Register eight nodes (extreme ids included), then overflow the table
  task automatic test_fill_and_overflow();
    send_item(CMD_HEARTBEAT, 32'h0000_0000, 32'd100);
    send_item(CMD_HEARTBEAT, 32'hFFFF_FFFF, 32'd200);
    for (int k = 0; k < 6; k++) begin
      send_item(CMD_HEARTBEAT, 32'hA5A5_0000 | k, 32'd300 + 32'(100 * k));
    end
    send_item(CMD_HEARTBEAT, 32'h5A5A_5A5A, 32'd900);
  endtask

  // Refresh with a stamp just before time wrap; hits with both lookup codes
  task automatic test_refresh_and_lookup();
    send_item(CMD_HEARTBEAT, 32'hFFFF_FFFF, 32'hFFFF_FF00);
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd1100);
    send_item(CMD_LOOKUP_ALT, 32'hA5A5_0003, 32'd1100);
    send_item(CMD_LOOKUP, 32'h5A5A_5A5A, 32'd1100);
  endtask

  // Reset timeout of 5000: elapsed equal to timeout stays, one above goes
  task automatic test_sweep_boundary();
    send_item(CMD_SWEEP, 32'h1234_5678, 32'd5300);
    send_item(CMD_SWEEP, 32'hEDCB_A987, 32'd5301);
    send_item(CMD_SWEEP, 32'h0000_0000, 32'd5301);
    send_item(CMD_HEARTBEAT, 32'h5A5A_5A5A, 32'd5400);
    // evicted slot keeps its old id but must not match
    send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd5400);
    // sweep at time zero: wrapped elapsed time evicts everything
    send_item(CMD_SWEEP, 32'hFFFF_FFFF, 32'd0);
  endtask

  // Zero timeout keeps only slots stamped at exactly the sweep time
  task automatic test_zero_timeout();
    write_timeout(32'd0);
    send_item(CMD_HEARTBEAT, 32'h0000_0000, 32'd7000);
    send_item(CMD_HEARTBEAT, 32'h0000_0001, 32'd7001);
    send_item(CMD_SWEEP, 32'd0, 32'd7001);
    send_item(CMD_SWEEP, 32'd0, 32'd7001);
  endtask

  // Widest timeout: nothing can ever be evicted
  task automatic test_widest_timeout();
    write_timeout(32'hFFFF_FFFF);
    send_item(CMD_HEARTBEAT, 32'h0000_FFFF, 32'd0);
    send_item(CMD_SWEEP, 32'hFFFF_0000, 32'hFFFF_FFFF);
  endtask

  // Random traffic over a small node pool under one timeout setting
  task automatic test_random_phase(input logic [31:0] timeout, input int count,
                                   input int step_max);
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [31:0] now;
    int          pick;
    int          k;
    write_timeout(timeout);
    // pool larger than the table so it fills and drops
    foreach (node_pool[p]) node_pool[p] = $urandom();
    if ($urandom_range(0, 1)) node_pool[0] = '0;
    if ($urandom_range(0, 1)) node_pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 63) == 0) begin
        clock_ms = $urandom();
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
      end
      now  = clock_ms;
      id   = node_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 6) == 0) id = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cmd = CMD_HEARTBEAT;
      end else if (pick < 72) begin
        cmd = CMD_SWEEP;
        id  = $urandom();
        // aim some sweeps right at a slot's eviction threshold
        k = $urandom_range(0, SLOTS - 1);
        if (slot_used[k] && $urandom_range(0, 2) == 0) begin
          now      = slot_stamp[k] + timeout_cur + $urandom_range(0, 2) - 1;
          clock_ms = now;
        end
      end else begin
        cmd = ($urandom_range(0, 3) == 0) ? CMD_LOOKUP_ALT : CMD_LOOKUP;
      end
      send_item(cmd, id, now);
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  // Test sequence
  initial begin
    logic [31:0] mid_timeout;
    logic [31:0] tight_timeout;
    timeout_cur = TIMEOUT_RESET;
    clock_ms    = 32'd8000;
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s]  = 1'b0;
      slot_id[s]    = '0;
      slot_stamp[s] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_overflow();
    test_refresh_and_lookup();
    test_sweep_boundary();
    test_zero_timeout();
    test_widest_timeout();

    mid_timeout   = $urandom_range(1000, 200000);
    tight_timeout = $urandom_range(2, 64);
    test_random_phase(32'hFFFF_FFFF, 200, 2000000);
    test_random_phase(32'd1, 250, 2);
    test_random_phase(mid_timeout, 300, mid_timeout / 4);
    test_random_phase(32'd0, 150, 1);
    test_random_phase(TIMEOUT_RESET, 400, 900);
    test_random_phase(tight_timeout, 350, tight_timeout / 3 + 1);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Run: %0d transactions through %0d timeout writes, %0d results checked",
             items_sent, timeout_writes, results_checked);
    $display("Seen: %0d refresh %0d register %0d full %0d hit %0d miss %0d sweep (%0d evicting)",
             status_tally[ST_REFRESHED], status_tally[ST_REGISTERED], status_tally[ST_FULL],
             status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_SWEPT],
             evicting_sweeps);
    if (error_count == 0) begin
      $display("tb_heartbeat_node_presence_table OK");
    end else begin
      $display("tb_heartbeat_node_presence_table NOT OK");
    end
    $finish;
  end

endmodule
